>>> sv/vbd_pkg.sv
// ----------------------------------------------------------------------------
// vbd_pkg
// Types and constants shared by the vertical blur deinterlacer files.
// ----------------------------------------------------------------------------
`default_nettype none

package vbd_pkg;

    // configuration register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 13;
    localparam int FW_REG_W     = 12;
    localparam int FH_REG_W     = 13;
    localparam logic [FW_REG_W-1:0] FW_RESET = 12'd640;
    localparam logic [FH_REG_W-1:0] FH_RESET = 13'd480;

    localparam int PIX_W = 8;
    localparam int ROW_OUT_W = 12;
    localparam int COL_OUT_W = 11;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic [PIX_W-1:0]     pixel_out;
        logic [ROW_OUT_W-1:0] out_row;
        logic [COL_OUT_W-1:0] out_col;
        logic                 last_of_run;
    } t_res;

    typedef struct packed {
        logic [1:0] n;       // entries pushed this cycle, first goes ahead
        t_res       first;
        t_res       second;
    } t_rq_push;

    typedef struct packed {
        logic [RQ_CW-1:0] count;
        logic             not_empty;
    } t_rq_stat;

endpackage

`default_nettype wire

>>> sv/vbd_pix_if.sv
// ----------------------------------------------------------------------------
// vbd_pix_if
// Source pixel stream: valid/ready handshake with one luma pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbd_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_in;

    modport source (output valid, output pixel_in, input ready);
    modport sink   (input valid, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> sv/vbd_res_if.sv
// ----------------------------------------------------------------------------
// vbd_res_if
// Result stream: valid/ready handshake with a pixel and its position.
// ----------------------------------------------------------------------------
`default_nettype none

interface vbd_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  pixel_out;
    logic [11:0] out_row;
    logic [10:0] out_col;
    logic        last_of_run;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output last_of_run, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

>>> sv/vbd_rq.sv
// ----------------------------------------------------------------------------
// vbd_rq
// Small result queue: takes up to two results per cycle, hands out one.
// ----------------------------------------------------------------------------
`default_nettype none

module vbd_rq (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire vbd_pkg::t_rq_push i_push,
    input  wire logic              i_pop,
    output vbd_pkg::t_res          o_head,
    output vbd_pkg::t_rq_stat      o_stat
);
    import vbd_pkg::*;

    t_res             r_mem [RQ_DEPTH];
    logic [RQ_AW-1:0] r_wr, n_wr;
    logic [RQ_AW-1:0] r_rd, n_rd;
    logic [RQ_CW-1:0] r_cnt, n_cnt;
    logic             pop_ok;

    assign pop_ok = i_pop && (r_cnt != '0);

    always_comb begin
        n_wr  = r_wr + RQ_AW'(i_push.n);
        n_rd  = r_rd + RQ_AW'(pop_ok);
        n_cnt = r_cnt + RQ_CW'(i_push.n) - RQ_CW'(pop_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.n != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.n == 2'd2) begin
            r_mem[r_wr + RQ_AW'(1)] <= i_push.second;
        end
    end

    assign o_head           = r_mem[r_rd];
    assign o_stat.count     = r_cnt;
    assign o_stat.not_empty = (r_cnt != '0);

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= RQ_CW'(RQ_DEPTH))
        else $error("result queue overflow");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_wr == r_rd))
        else $error("result queue pointers disagree with empty count");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == RQ_CW'(RQ_DEPTH)) |-> (i_push.n == 2'd0))
        else $error("push into full result queue");

endmodule

`default_nettype wire

>>> sv/vertical_blur_deinterlacer_unit.sv
// ----------------------------------------------------------------------------
// vertical_blur_deinterlacer_unit
// Vertical [1 2 1] blur deinterlacer over a raster luma stream.
//
//   channel  dir  handshake          payload
//   i_pix    in   valid/ready        pixel_in
//   o_res    out  valid/ready        pixel_out, out_row, out_col, last_of_run
//   cfg      in   i_cfg_we (no wait) i_cfg_index, i_cfg_data
//
// One pixel accepted per cycle while the result queue has room; a result goes
// through stage 1 and then the result queue. Pixels of the last row give two
// results each, so there the output side sets the pace. The line store is one
// memory word {above, centre} per column: read on accept, written back the
// next cycle, with a forward for back-to-back pixels of the same column.
// Reset needs no clearing pass. The input stalls only on result queue room.
// ----------------------------------------------------------------------------
`default_nettype none

module vertical_blur_deinterlacer_unit #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    vbd_pix_if.sink                                 i_pix,
    vbd_res_if.source                               o_res,
    input  wire logic                               i_cfg_we,
    input  wire logic [vbd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [vbd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import vbd_pkg::*;

    localparam int COL_W  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WCMP_W = (COL_W + 1 > FW_REG_W) ? COL_W + 1 : FW_REG_W;
    localparam int HCMP_W = (ROW_W + 1 > FH_REG_W) ? ROW_W + 1 : FH_REG_W;
    localparam int WORD_W = 2 * PIX_W;

    // configuration
    logic [FW_REG_W-1:0] r_frame_width;
    logic [FH_REG_W-1:0] r_frame_height;
    logic [WCMP_W-1:0]   eff_w, fw_ext;
    logic [HCMP_W-1:0]   eff_h, fh_ext;

    // counters
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [WCMP_W-1:0] col_p1;
    logic [HCMP_W-1:0] row_p1;
    logic              last_row;

    // stage 1: line store data returns
    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [PIX_W-1:0]  r_s1_pix;
    logic              r_s1_last;
    logic [1:0]        r_s1_n;
    logic              r_s1_hit;
    logic [WORD_W-1:0] r_fwd;
    logic [WORD_W-1:0] r_mem_q;
    logic [WORD_W-1:0] line_mem [MAX_WIDTH];

    logic              accept;
    logic [1:0]        acc_n;
    logic [WORD_W-1:0] s1_word, s1_wdata;
    logic [PIX_W-1:0]  s1_above, s1_centre;
    logic [PIX_W+1:0]  blur_sum;
    logic [PIX_W-1:0]  s1_value;
    logic [3:0]        room;

    t_rq_push push;
    t_res     head;
    t_rq_stat rq_stat;

    // ---------------- configuration ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_REG_W-1:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        fw_ext = WCMP_W'(r_frame_width);
        fh_ext = HCMP_W'(r_frame_height);
        if (fw_ext == '0) begin
            eff_w = WCMP_W'(1);
        end else if (fw_ext > WCMP_W'(MAX_WIDTH)) begin
            eff_w = WCMP_W'(MAX_WIDTH);
        end else begin
            eff_w = fw_ext;
        end
        if (fh_ext < HCMP_W'(2)) begin
            eff_h = HCMP_W'(2);
        end else if (fh_ext > HCMP_W'(MAX_HEIGHT)) begin
            eff_h = HCMP_W'(MAX_HEIGHT);
        end else begin
            eff_h = fh_ext;
        end
    end

    // ---------------- accept and counters ----------------
    // room for everything in flight plus two more results
    assign room         = 4'(rq_stat.count) + 4'(r_s1_valid ? r_s1_n : 2'd0) + 4'd2;
    assign i_pix.ready  = (room <= 4'(RQ_DEPTH));
    assign accept       = i_pix.valid && i_pix.ready;

    assign col_p1   = WCMP_W'(r_col) + WCMP_W'(1);
    assign row_p1   = HCMP_W'(r_row) + HCMP_W'(1);
    assign last_row = (row_p1 >= eff_h);
    assign acc_n    = (r_row == '0) ? 2'd0 : (last_row ? 2'd2 : 2'd1);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (col_p1 >= eff_w) begin
                n_col = '0;
                n_row = last_row ? '0 : ROW_W'(row_p1);
            end else begin
                n_col = COL_W'(col_p1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_col <= '0;
                r_row <= '0;
            end else begin
                r_col <= n_col;
                r_row <= n_row;
            end
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col  <= r_col;
            r_s1_row  <= r_row;
            r_s1_pix  <= i_pix.pixel_in;
            r_s1_last <= last_row;
            r_s1_n    <= acc_n;
            // previous pixel writes this column at this very edge
            r_s1_hit  <= r_s1_valid && (r_s1_col == r_col);
            r_fwd     <= s1_wdata;
        end
    end

    // ---------------- line store ----------------
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem_q <= line_mem[r_col];
        end
        if (r_s1_valid) begin
            line_mem[r_s1_col] <= s1_wdata;
        end
    end

    assign s1_word   = r_s1_hit ? r_fwd : r_mem_q;
    assign s1_above  = s1_word[WORD_W-1:PIX_W];
    assign s1_centre = s1_word[PIX_W-1:0];
    assign s1_wdata  = {s1_centre, r_s1_pix};

    assign blur_sum = {2'b00, s1_above} + {1'b0, s1_centre, 1'b0}
                    + {2'b00, r_s1_pix} + (PIX_W+2)'(2);
    assign s1_value = (r_s1_row == ROW_W'(1)) ? s1_centre : blur_sum[PIX_W+1:2];

    // ---------------- results ----------------
    always_comb begin
        push.n                  = r_s1_valid ? r_s1_n : 2'd0;
        push.first.pixel_out    = s1_value;
        push.first.out_row      = ROW_OUT_W'(r_s1_row - ROW_W'(1));
        push.first.out_col      = COL_OUT_W'(r_s1_col);
        push.first.last_of_run  = !r_s1_last;
        push.second.pixel_out   = r_s1_pix;
        push.second.out_row     = ROW_OUT_W'(r_s1_row);
        push.second.out_col     = COL_OUT_W'(r_s1_col);
        push.second.last_of_run = 1'b1;
    end

    vbd_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (o_res.ready),
        .o_head  (head),
        .o_stat  (rq_stat)
    );

    assign o_res.valid       = rq_stat.not_empty;
    assign o_res.pixel_out   = head.pixel_out;
    assign o_res.out_row     = head.out_row;
    assign o_res.out_col     = head.out_col;
    assign o_res.last_of_run = head.last_of_run;

    // ---------------- checks ----------------
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_hit) |-> ($past(r_s1_valid) && ($past(r_s1_col) == r_s1_col)))
        else $error("forward taken without a same-column predecessor");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WCMP_W'(r_col) < eff_w)
        else $error("column counter beyond frame width");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        HCMP_W'(r_row) < eff_h)
        else $error("row counter beyond frame height");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_s1_last) |-> (r_s1_n == 2'd2))
        else $error("last row pixel without its copy result");

endmodule

`default_nettype wire

>>> sim/vbd_checker.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// vbd_checker
// Watches the pixel, result and register ports of the vertical blur
// deinterlacer, predicts every result from the accepted pixels and the
// register writes, and compares each accepted result field by field.
// ----------------------------------------------------------------------------

module vbd_checker #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    vbd_pix_if                                  i_pix,
    vbd_res_if                                  i_res,
    input  wire logic                           i_cfg_we,
    input  wire logic [vbd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [vbd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import vbd_pkg::*;

    localparam int MAX_PRINTED = 40;

    logic [PIX_W-1:0]     line_above  [MAX_WIDTH];
    logic [PIX_W-1:0]     line_centre [MAX_WIDTH];
    logic [COL_OUT_W-1:0] col_pos;
    logic [ROW_OUT_W-1:0] row_pos;
    logic [FW_REG_W-1:0]  frame_width;
    logic [FH_REG_W-1:0]  frame_height;
    t_res                 expected_q [$];
    int                   fail_count = 0;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t vbd_checker: %s", $time, msg);
    endtask

    function automatic int unsigned active_width();
        if (frame_width == '0) return 1;
        if (frame_width > MAX_WIDTH) return MAX_WIDTH;
        return frame_width;
    endfunction

    function automatic int unsigned active_height();
        if (frame_height < 2) return 2;
        if (frame_height > MAX_HEIGHT) return MAX_HEIGHT;
        return frame_height;
    endfunction

    // One source pixel: emits the line above it (one line of lag) and, on the
    // last source line, a straight copy of the pixel itself.
    task automatic blur_pixel(input logic [PIX_W-1:0] pix);
        int unsigned      w;
        int unsigned      h;
        int unsigned      sum;
        logic [PIX_W-1:0] above;
        logic [PIX_W-1:0] centre;
        bit               on_last_row;
        t_res             r;
        w = active_width();
        h = active_height();
        above = line_above[col_pos];
        centre = line_centre[col_pos];
        on_last_row = (32'(row_pos) + 1 >= h);
        if (row_pos != '0) begin
            if (row_pos == 1) begin
                r.pixel_out = centre;   // first line passes through unfiltered
            end else begin
                sum = 32'(above) + 2 * 32'(centre) + 32'(pix) + 2;
                r.pixel_out = PIX_W'(sum >> 2);
            end
            r.out_row = row_pos - 1'b1;
            r.out_col = col_pos;
            r.last_of_run = !on_last_row;
            expected_q.push_back(r);
        end
        if (on_last_row) begin
            r.pixel_out = pix;
            r.out_row = row_pos;
            r.out_col = col_pos;
            r.last_of_run = 1'b1;
            expected_q.push_back(r);
        end
        line_above[col_pos] = centre;
        line_centre[col_pos] = pix;
        if (32'(col_pos) + 1 >= w) begin
            col_pos = '0;
            if (32'(row_pos) + 1 >= h) row_pos = '0;
            else row_pos = row_pos + 1'b1;
        end else begin
            col_pos = col_pos + 1'b1;
        end
    endtask

    task automatic check_result(input t_res got);
        t_res want;
        if (expected_q.size() == 0) begin
            report_mismatch($sformatf("unexpected result pixel %0d row %0d col %0d last %0d",
                                      got.pixel_out, got.out_row, got.out_col, got.last_of_run));
            return;
        end
        want = expected_q.pop_front();
        if (got.pixel_out !== want.pixel_out)
            report_mismatch($sformatf("row %0d col %0d: pixel_out %0d, want %0d",
                                      want.out_row, want.out_col, got.pixel_out, want.pixel_out));
        if (got.out_row !== want.out_row)
            report_mismatch($sformatf("row %0d col %0d: out_row %0d",
                                      want.out_row, want.out_col, got.out_row));
        if (got.out_col !== want.out_col)
            report_mismatch($sformatf("row %0d col %0d: out_col %0d",
                                      want.out_row, want.out_col, got.out_col));
        if (got.last_of_run !== want.last_of_run)
            report_mismatch($sformatf("row %0d col %0d: last_of_run %0b, want %0b",
                                      want.out_row, want.out_col, got.last_of_run,
                                      want.last_of_run));
    endtask

    always @(posedge i_clk) begin : scoreboard
        t_res got;
        if (!i_rst_n) begin
            col_pos = '0;
            row_pos = '0;
            frame_width = FW_RESET;
            frame_height = FH_RESET;
            expected_q.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got.pixel_out = i_res.pixel_out;
                got.out_row = i_res.out_row;
                got.out_col = i_res.out_col;
                got.last_of_run = i_res.last_of_run;
                check_result(got);
            end
            // any register write restarts the frame
            if (i_cfg_we) begin
                if (i_cfg_index == REG_FRAME_WIDTH) frame_width = i_cfg_data[FW_REG_W-1:0];
                else frame_height = i_cfg_data[FH_REG_W-1:0];
                col_pos = '0;
                row_pos = '0;
            end
            if (i_pix.valid && i_pix.ready)
                blur_pixel(i_pix.pixel_in);
        end
        o_pending = expected_q.size();
    end

endmodule

`default_nettype wire

>>> sim/tb.sv
`timescale 1ns / 100ps
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Stimulus for the vertical blur deinterlacer: directed frames for the size
// clamps, two-line frames and full-scale sums, then random frame geometries
// with random pixels, bursty stalls on both sides and a long output stall.
// ----------------------------------------------------------------------------

module tb;
    import vbd_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int RANDOM_PIXELS = 1550;
    localparam int CALM_TAIL     = 250;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    fail_count;
    int                    pending;
    bit                    src_gaps;
    bit                    sink_gaps;
    int                    sink_hold;

    vbd_pix_if pix_ch ();
    vbd_res_if res_ch ();

    vertical_blur_deinterlacer_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    vbd_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pix        (pix_ch),
        .i_res        (res_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // result side: random stall bursts, plus a long hold-off on request
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_hold > 0) begin
                stall_left = sink_hold;
                sink_hold = 0;
            end
            if (!i_rst_n) begin
                res_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= 1'b0;
            end else begin
                res_ch.ready <= 1'b1;
                if (sink_gaps && $urandom_range(0, 9) == 0)
                    stall_left = $urandom_range(1, 19);
            end
        end
    end

    initial begin : watchdog
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_we)
                idle = 0;
            else
                idle++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic int unsigned clamp_width(input int unsigned width);
        int unsigned w;
        w = width % 4096;
        if (w == 0) return 1;
        if (w > 2048) return 2048;
        return w;
    endfunction

    function automatic int unsigned clamp_height(input int unsigned height);
        if (height < 2) return 2;
        if (height > 4096) return 4096;
        return height;
    endfunction

    // starts and ends on a falling edge; valid stays up between transfers unless a source gap is drawn
    task automatic put_pixel(input logic [7:0] value);
        if (src_gaps && $urandom_range(0, 7) == 0) begin
            pix_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel_in <= value;
        do @(posedge i_clk); while (!pix_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        pix_ch.valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        wait_drained();
        repeat (4) @(negedge i_clk);   // row-0 pixels leave no result to wait on
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // width writes carry a random bit above the register, which is dropped
    task automatic set_frame(input int unsigned width, input int unsigned height);
        int unsigned wdata;
        wdata = width | ($urandom_range(0, 1) << FW_REG_W);
        if ($urandom_range(0, 1) == 0) begin
            write_reg(REG_FRAME_WIDTH, wdata);
            write_reg(REG_FRAME_HEIGHT, height);
        end else begin
            write_reg(REG_FRAME_HEIGHT, height);
            write_reg(REG_FRAME_WIDTH, wdata);
        end
    endtask

    initial begin : stimulus
        int unsigned w;
        int unsigned h;
        int unsigned count;
        int          pause_at;
        int          hold_at;
        int          random_done;
        int          phase;
        bit          widest;
        i_rst_n = 1'b0;
        pix_ch.valid = 1'b0;
        pix_ch.pixel_in = '0;
        cfg_we = 1'b0;
        cfg_index = REG_FRAME_WIDTH;
        cfg_data = '0;
        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        sink_hold = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset geometry: a few pixels of the first line, nothing comes out
        repeat (3) put_pixel(rand_pixel());

        // two-line frame (height 0 acts as 2): copies of both lines
        set_frame(3, 0);
        put_pixel(8'h00);
        put_pixel(8'hFF);
        put_pixel(8'h80);
        put_pixel(8'hFF);
        put_pixel(8'h00);
        put_pixel(8'h01);

        // width 0 acts as 1; full-scale sum must not wrap, then a second frame
        set_frame(0, 3);
        repeat (3) put_pixel(8'hFF);
        put_pixel(8'h00);
        put_pixel(8'hFF);
        put_pixel(8'h00);

        // height past the maximum, single column, last line never reached
        set_frame(1, 8191);
        put_pixel(8'h55);
        put_pixel(8'hAA);
        put_pixel(8'h0F);
        put_pixel(8'hF0);
        put_pixel(8'hFF);
        put_pixel(8'h00);

        random_done = 0;
        phase = 0;
        while (random_done < RANDOM_PIXELS) begin
            widest = (phase == 2);
            pause_at = -1;
            hold_at = -1;
            if (widest) begin
                // register at or past the limit: lines of MAX_WIDTH, into the second line
                w = $urandom_range(2048, 4095);
                h = $urandom_range(2, 3);
                count = 2048 + 12;
                hold_at = 2048;
            end else if (phase == 1) begin
                w = $urandom_range(4, 10);
                h = $urandom_range(2, 4);
                count = w * h * 2;
                hold_at = w;
                pause_at = count / 2;
            end else begin
                case ($urandom_range(0, 9))
                    0: begin
                        w = $urandom_range(0, 3);
                        h = ($urandom_range(0, 1) == 0) ? $urandom_range(4097, 8191)
                                                        : $urandom_range(5, 4096);
                        count = $urandom_range(10, 60);
                    end
                    1: begin
                        w = $urandom_range(11, 4095);
                        h = $urandom_range(0, 8191);
                        count = $urandom_range(1, 40);
                    end
                    default: begin
                        w = $urandom_range(0, 10);
                        h = $urandom_range(0, 7);
                        count = clamp_width(w) * clamp_height(h) * $urandom_range(1, 3);
                        // a frame cut short by the next register write
                        if ($urandom_range(0, 3) == 0) count = $urandom_range(1, count);
                    end
                endcase
                if ($urandom_range(0, 5) == 0) pause_at = $urandom_range(0, count - 1);
            end
            if (random_done + count > RANDOM_PIXELS - CALM_TAIL && !widest) begin
                src_gaps = 1'b0;
                sink_gaps = 1'b0;
            end else begin
                src_gaps = (phase != 1) && ($urandom_range(0, 3) != 0);
                sink_gaps = (phase != 1) && ($urandom_range(0, 3) != 0);
            end
            set_frame(w, h);
            for (int k = 0; k < count; k++) begin
                if (k == pause_at) wait_drained();
                if (k == hold_at) sink_hold = $urandom_range(150, 300);
                put_pixel(rand_pixel());
            end
            if (!widest) random_done += count;
            phase++;
        end

        src_gaps = 1'b0;
        sink_gaps = 1'b0;
        wait_drained();
        repeat (10) @(negedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
